// File: src/lsps_pkg.sv
package lsps_pkg;

  // Width of the Q1.14 quotients and of the normal root (0 .. 16384).
  localparam int unsigned QW = 15;
  localparam int unsigned QF = 14;

  localparam int unsigned DefMaxSpriteSize = 256;

  localparam int unsigned QOne      = 16384;
  localparam int unsigned KAmbient  = 4915;
  localparam int unsigned KDiffuse  = 11469;
  localparam int unsigned KBumpBase = 12288;
  localparam int unsigned KGainCap  = 26214;
  localparam int unsigned KRim      = 11469;

  typedef enum logic [2:0] {
    REG_BASE_RED,
    REG_BASE_GREEN,
    REG_BASE_BLUE,
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_SPRITE_SIZE
  } cfg_reg_e;

  typedef struct packed {
    logic        sign_x;
    logic        sign_y;
    logic        covered;
    logic        rim;
    logic [14:0] bump;
  } side_div_t;

  typedef struct packed {
    logic               covered;
    logic               rim;
    logic        [14:0] bump;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } side_sqrt_t;

endpackage

// File: src/lsps_div.sv
module lsps_div #(
  parameter int unsigned DW = 9,
  parameter int unsigned AW = 9
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [AW-1:0]          num_i,
  input  logic [DW-1:0]          den_i,
  output logic [lsps_pkg::QW-1:0] quot_o
);
  import lsps_pkg::*;

  // Computes floor(num * 2^14 / den) one quotient bit per stage. The result is
  // exact whenever num <= den; other inputs give a value that is not used.
  localparam int unsigned RW = DW + 1;

  logic [RW-1:0] rem_q [QW];
  logic [RW-1:0] rem_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];
  logic [RW:0]   trial [QW];
  logic [RW-1:0] num_ext;

  assign num_ext = RW'(num_i);

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        trial[k] = {1'b0, num_ext};
        quo_d[k] = '0;
      end else begin
        trial[k] = {rem_q[k-1], 1'b0};
        quo_d[k] = quo_q[k-1];
      end
      if (trial[k] >= {2'b00, den_i}) begin
        rem_d[k] = RW'(trial[k] - {2'b00, den_i});
        quo_d[k] = quo_d[k] | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_d[k] = RW'(trial[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quot_o = quo_q[QW-1];

endmodule

// File: src/lsps_sqrt.sv
module lsps_sqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [2*lsps_pkg::QW-2:0] val_i,
  output logic [lsps_pkg::QW-1:0]   root_o
);
  import lsps_pkg::*;

  // Integer square root, one result bit per stage.
  localparam int unsigned VW = 2 * QW;

  logic [VW-1:0] val_q  [QW];
  logic [VW-1:0] val_d  [QW];
  logic [VW-1:0] root_q [QW];
  logic [VW-1:0] root_d [QW];
  logic [VW-1:0] cur_v  [QW];
  logic [VW-1:0] cur_r  [QW];
  logic [VW-1:0] bitv   [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      bitv[k] = VW'(1) << (2 * (QW - 1 - k));
      if (k == 0) begin
        cur_v[k] = VW'(val_i);
        cur_r[k] = '0;
      end else begin
        cur_v[k] = val_q[k-1];
        cur_r[k] = root_q[k-1];
      end
      if (cur_v[k] >= cur_r[k] + bitv[k]) begin
        val_d[k]  = cur_v[k] - (cur_r[k] + bitv[k]);
        root_d[k] = (cur_r[k] >> 1) + bitv[k];
      end else begin
        val_d[k]  = cur_v[k];
        root_d[k] = cur_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        val_q[k]  <= val_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[QW-1][QW-1:0];

endmodule

// File: src/lit_sphere_pixel_shader.sv
// Throughput: one word per cycle; the pipeline holds 39 words and the whole
// pipeline stalls only while a finished result waits at the output.
// The 15-stage dividers and the 15-stage square root set the depth.
// Reset clears all valid bits and loads the configuration reset values.
module lit_sphere_pixel_shader #(
  parameter int unsigned MAX_SPRITE_SIZE = lsps_pkg::DefMaxSpriteSize
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [7:0]  noise_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        covered_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);
  import lsps_pkg::*;

  localparam int unsigned SizeHi  = (MAX_SPRITE_SIZE > 511) ? 511 : MAX_SPRITE_SIZE;
  localparam logic [8:0]  SizeHiW = 9'(SizeHi);
  localparam logic [8:0]  SizeLoW = 9'd4;
  localparam int unsigned StC     = 2;
  localparam int unsigned NStages = StC + 2 * QW + 7;

  // Configuration registers.
  logic        [7:0]  base_r_q, base_g_q, base_b_q;
  logic signed [15:0] light_x_q, light_y_q, light_z_q;
  logic        [8:0]  size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_r_q  <= 8'd128;
      base_g_q  <= 8'd122;
      base_b_q  <= 8'd116;
      light_x_q <= -16'sd9011;
      light_y_q <= -16'sd9830;
      light_z_q <= 16'sd9503;
      size_q    <= 9'd56;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE_RED:    base_r_q  <= cfg_data_i[7:0];
        REG_BASE_GREEN:  base_g_q  <= cfg_data_i[7:0];
        REG_BASE_BLUE:   base_b_q  <= cfg_data_i[7:0];
        REG_LIGHT_X:     light_x_q <= cfg_data_i;
        REG_LIGHT_Y:     light_y_q <= cfg_data_i;
        REG_LIGHT_Z:     light_z_q <= cfg_data_i;
        REG_SPRITE_SIZE: size_q    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Values derived from the sprite size; den and den2 are registered, n_eff is combinational.
  logic [8:0]  n_eff;
  logic [8:0]  den_d, den_q;
  logic [17:0] den2_d, den2_q;

  always_comb begin
    if (size_q < SizeLoW) begin
      n_eff = SizeLoW;
    end else if (size_q > SizeHiW) begin
      n_eff = SizeHiW;
    end else begin
      n_eff = size_q;
    end
    den_d  = n_eff - 9'd2;
    den2_d = 18'(den_d) * 18'(den_d);
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    den2_q <= den2_d;
  end

  // Pipeline control: every stage moves together.
  logic               en;
  logic [NStages-1:0] v_q;

  assign en          = !v_q[NStages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStages-2:0], in_valid_i};
    end
  end

  // Stage A: input word.
  logic [7:0] a_x_q, a_y_q, a_noise_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q     <= pixel_x_i;
      a_y_q     <= pixel_y_i;
      a_noise_q <= noise_level_i;
    end
  end

  // Stage B: centered coordinates, squares and the bump factor.
  logic signed [10:0] ux, uy;
  logic        [8:0]  abs_x_d, abs_y_d;
  logic        [12:0] noise32;
  logic        [5:0]  noise_q255;
  logic        [14:0] bump_d;
  logic        [8:0]  b_abs_x_q, b_abs_y_q;
  logic               b_sx_q, b_sy_q;
  logic        [17:0] b_sqx_q, b_sqy_q;
  logic        [14:0] b_bump_q;

  always_comb begin
    ux      = $signed({2'b00, a_x_q, 1'b1}) - $signed({2'b00, n_eff});
    uy      = $signed({2'b00, a_y_q, 1'b1}) - $signed({2'b00, n_eff});
    abs_x_d = ux[10] ? 9'(-ux) : ux[8:0];
    abs_y_d = uy[10] ? 9'(-uy) : uy[8:0];
    // 8192*noise/255 = 32*noise + floor(32*noise/255).
    noise32    = {a_noise_q, 5'b0};
    noise_q255 = 6'((14'(noise32) + 14'(noise32 >> 8) + 14'd1) >> 8);
    bump_d     = 15'(KBumpBase) + 15'(noise32) + 15'(noise_q255);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_abs_x_q <= abs_x_d;
      b_abs_y_q <= abs_y_d;
      b_sx_q    <= ux[10];
      b_sy_q    <= uy[10];
      b_sqx_q   <= abs_x_d * abs_x_d;
      b_sqy_q   <= abs_y_d * abs_y_d;
      b_bump_q  <= bump_d;
    end
  end

  // Stage C: squared radius, disc and rim tests.
  logic [18:0] s_d;
  logic        cov_d, rim_d;
  logic [18:0] c_s_q;
  logic [8:0]  c_abs_x_q, c_abs_y_q;
  side_div_t   c_side_q;

  always_comb begin
    s_d   = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
    cov_d = s_d <= {1'b0, den2_q};
    rim_d = (26'(s_d) * 26'd100) > (26'(den2_q) * 26'd86);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_s_q            <= s_d;
      c_abs_x_q        <= b_abs_x_q;
      c_abs_y_q        <= b_abs_y_q;
      c_side_q.sign_x  <= b_sx_q;
      c_side_q.sign_y  <= b_sy_q;
      c_side_q.covered <= cov_d;
      c_side_q.rim     <= rim_d;
      c_side_q.bump    <= b_bump_q;
    end
  end

  // Dividers: dx, dy and d2 in Q1.14.
  logic [QW-1:0] qx, qy, qd2;

  lsps_div #(.DW(9), .AW(9)) u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (c_abs_x_q), .den_i (den_q), .quot_o (qx)
  );

  lsps_div #(.DW(9), .AW(9)) u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (c_abs_y_q), .den_i (den_q), .quot_o (qy)
  );

  lsps_div #(.DW(18), .AW(19)) u_div_d2 (
    .clk_i (clk_i), .en_i (en), .num_i (c_s_q), .den_i (den2_q), .quot_o (qd2)
  );

  side_div_t side_div_q [QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_div_q[0] <= c_side_q;
      for (int k = 1; k < QW; k++) begin
        side_div_q[k] <= side_div_q[k-1];
      end
    end
  end

  // Square root of (1 - d2), sign applied to dx and dy meanwhile.
  logic [2*QW-2:0]    sq_in;
  logic [QW-1:0]      nz;
  logic signed [15:0] dx_d, dy_d;
  side_sqrt_t         side_in;
  side_sqrt_t         side_sq_q [QW];

  always_comb begin
    sq_in = {15'(QOne) - qd2, 14'b0};
    dx_d  = side_div_q[QW-1].sign_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    dy_d  = side_div_q[QW-1].sign_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    side_in.covered = side_div_q[QW-1].covered;
    side_in.rim     = side_div_q[QW-1].rim;
    side_in.bump    = side_div_q[QW-1].bump;
    side_in.dx      = dx_d;
    side_in.dy      = dy_d;
  end

  lsps_sqrt u_sqrt (
    .clk_i (clk_i), .en_i (en), .val_i (sq_in), .root_o (nz)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_sq_q[0] <= side_in;
      for (int k = 1; k < QW; k++) begin
        side_sq_q[k] <= side_sq_q[k-1];
      end
    end
  end

  // Stage E: light products.
  logic signed [15:0] e_dx, e_dy;
  logic signed [31:0] e_px_q, e_py_q, e_pz_q;
  logic               e_cov_q, e_rim_q;
  logic        [14:0] e_bump_q;

  assign e_dx = side_sq_q[QW-1].dx;
  assign e_dy = side_sq_q[QW-1].dy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_px_q   <= e_dx * light_x_q;
      e_py_q   <= e_dy * light_y_q;
      e_pz_q   <= $signed({1'b0, nz}) * light_z_q;
      e_cov_q  <= side_sq_q[QW-1].covered;
      e_rim_q  <= side_sq_q[QW-1].rim;
      e_bump_q <= side_sq_q[QW-1].bump;
    end
  end

  // Stage F: diffuse term, clamped at zero.
  logic signed [33:0] dot;
  logic        [19:0] f_diff_q;
  logic               f_cov_q, f_rim_q;
  logic        [14:0] f_bump_q;

  assign dot = 34'(e_px_q) + 34'(e_py_q) + 34'(e_pz_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_diff_q <= dot[33] ? 20'd0 : dot[33:14];
      f_cov_q  <= e_cov_q;
      f_rim_q  <= e_rim_q;
      f_bump_q <= e_bump_q;
    end
  end

  // Stage G: ambient plus scaled diffuse.
  logic [33:0] diff_prod;
  logic [19:0] g_lin_q;
  logic        g_cov_q, g_rim_q;
  logic [14:0] g_bump_q;

  assign diff_prod = 34'(f_diff_q) * 34'(KDiffuse);

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_lin_q  <= 20'(KAmbient) + 20'(diff_prod >> QF);
      g_cov_q  <= f_cov_q;
      g_rim_q  <= f_rim_q;
      g_bump_q <= f_bump_q;
    end
  end

  // Stage H: gain with cap.
  logic [34:0] gain_prod;
  logic [20:0] gain_raw;
  logic [14:0] h_gain_q;
  logic        h_cov_q, h_rim_q;

  assign gain_prod = 35'(g_lin_q) * 35'(g_bump_q);
  assign gain_raw  = 21'(gain_prod >> QF);

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_gain_q <= (gain_raw > 21'(KGainCap)) ? 15'(KGainCap) : gain_raw[14:0];
      h_cov_q  <= g_cov_q;
      h_rim_q  <= g_rim_q;
    end
  end

  // Stage I: channel scaling with saturation.
  logic [22:0] pr, pg, pb;
  logic [7:0]  i_r_q, i_g_q, i_b_q;
  logic        i_cov_q, i_rim_q;

  assign pr = base_r_q * h_gain_q;
  assign pg = base_g_q * h_gain_q;
  assign pb = base_b_q * h_gain_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_r_q   <= (pr[22:QF] > 9'd255) ? 8'd255 : pr[21:QF];
      i_g_q   <= (pg[22:QF] > 9'd255) ? 8'd255 : pg[21:QF];
      i_b_q   <= (pb[22:QF] > 9'd255) ? 8'd255 : pb[21:QF];
      i_cov_q <= h_cov_q;
      i_rim_q <= h_rim_q;
    end
  end

  // Stage J: rim darkening and the output word.
  logic [21:0] rr, rg, rb;
  logic [7:0]  j_r_d, j_g_d, j_b_d;
  logic        j_cov_q;
  logic [7:0]  j_r_q, j_g_q, j_b_q;

  always_comb begin
    rr = i_r_q * 14'(KRim);
    rg = i_g_q * 14'(KRim);
    rb = i_b_q * 14'(KRim);
    if (!i_cov_q) begin
      j_r_d = '0;
      j_g_d = '0;
      j_b_d = '0;
    end else if (i_rim_q) begin
      j_r_d = rr[21:QF];
      j_g_d = rg[21:QF];
      j_b_d = rb[21:QF];
    end else begin
      j_r_d = i_r_q;
      j_g_d = i_g_q;
      j_b_d = i_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_cov_q <= i_cov_q;
      j_r_q   <= j_r_d;
      j_g_q   <= j_g_d;
      j_b_q   <= j_b_d;
    end
  end

  assign covered_o   = j_cov_q;
  assign out_red_o   = j_r_q;
  assign out_green_o = j_g_q;
  assign out_blue_o  = j_b_q;

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsps_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 50;

  typedef struct {
    bit       covered;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } pixel_color_t;

  class sphere_shade_board;
    bit [7:0]       base_r, base_g, base_b;
    shortint        lx, ly, lz;
    bit [8:0]       size;
    pixel_color_t   colors_due[$];
    int unsigned    mismatches;
    int unsigned    shaded_count;
    int unsigned    covered_count;
    int unsigned    rim_count;

    function void load_reset();
      base_r = 128;
      base_g = 122;
      base_b = 116;
      lx = -9011;
      ly = -9830;
      lz = 9503;
      size = 56;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [15:0] data);
      case (idx)
        REG_BASE_RED:    base_r = data[7:0];
        REG_BASE_GREEN:  base_g = data[7:0];
        REG_BASE_BLUE:   base_b = data[7:0];
        REG_LIGHT_X:     lx = shortint'(data);
        REG_LIGHT_Y:     ly = shortint'(data);
        REG_LIGHT_Z:     lz = shortint'(data);
        REG_SPRITE_SIZE: size = data[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned edge_len();
      if (size < 4) return 4;
      if (size > 256) return 256;
      return size;
    endfunction

    function longint root_floor(longint v);
      longint r;
      longint t;
      r = 0;
      for (int b = 14; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function longint unit_coord(longint u, longint den);
      longint q;
      q = ((u < 0 ? -u : u) * 16384) / den;
      return u < 0 ? -q : q;
    endfunction

    function bit [7:0] tint(bit [7:0] base, longint gain, bit rim);
      longint ch;
      ch = (longint'(base) * gain) >>> 14;
      if (ch > 255) ch = 255;
      if (rim) ch = (ch * 11469) >>> 14;
      return ch[7:0];
    endfunction

    function void note_pixel(bit [7:0] x, bit [7:0] y, bit [7:0] noise);
      longint n, den, den2, ux, uy, s, dx, dy, d2, nz, dot, diffuse, lin, bump, gain;
      bit rim;
      pixel_color_t c;
      n = edge_len();
      den = n - 2;
      den2 = den * den;
      ux = 2 * longint'(x) + 1 - n;
      uy = 2 * longint'(y) + 1 - n;
      s = ux * ux + uy * uy;
      shaded_count++;
      c = '{0, 0, 0, 0};
      if (s <= den2) begin
        rim = (100 * s) > (86 * den2);
        dx = unit_coord(ux, den);
        dy = unit_coord(uy, den);
        d2 = (s * 16384) / den2;
        if (d2 > 16384) d2 = 16384;
        nz = root_floor((16384 - d2) * 16384);
        dot = dx * longint'(lx) + dy * longint'(ly) + nz * longint'(lz);
        diffuse = dot < 0 ? 0 : (dot >>> 14);
        lin = 4915 + ((11469 * diffuse) >>> 14);
        bump = 12288 + (8192 * longint'(noise)) / 255;
        gain = (lin * bump) >>> 14;
        if (gain > 26214) gain = 26214;
        c.covered = 1;
        c.red = tint(base_r, gain, rim);
        c.green = tint(base_g, gain, rim);
        c.blue = tint(base_b, gain, rim);
        covered_count++;
        if (rim) rim_count++;
      end
      colors_due.push_back(c);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_color(pixel_color_t got);
      pixel_color_t want;
      if (colors_due.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = colors_due.pop_front();
        if (got.covered != want.covered) report("covered", got.covered, want.covered);
        if (got.red != want.red) report("out_red", got.red, want.red);
        if (got.green != want.green) report("out_green", got.green, want.green);
        if (got.blue != want.blue) report("out_blue", got.blue, want.blue);
      end
    endtask
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  logic [7:0] pixel_x_i = '0;
  logic [7:0] pixel_y_i = '0;
  logic [7:0] noise_level_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  logic       covered_o;
  logic [7:0] out_red_o, out_green_o, out_blue_o;

  sphere_shade_board board = new();
  bit          idling = 1;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  lit_sphere_pixel_shader u_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_color('{covered_o, out_red_o, out_green_o, out_blue_o});
  end

  // The watchdog only counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Timeout after %0d idle cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = idling ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready_i <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task send_pixel(bit [7:0] x, bit [7:0] y, bit [7:0] noise, bit may_idle);
    int unsigned gap;
    gap = (idling && may_idle) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    noise_level_i <= noise;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_pixel(x, y, noise);
  endtask

  task wait_drained();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (board.colors_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves the write channel valid so that writes can follow back to back;
  // the caller drops cfg_valid_i after the last write.
  task write_reg(cfg_reg_e idx, bit [15:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task random_pixels(int unsigned count);
    int unsigned n;
    bit [7:0] x, y;
    n = board.edge_len();
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) begin
        x = $urandom_range(0, n - 1);
        y = $urandom_range(0, n - 1);
      end else begin
        x = $urandom;
        y = $urandom;
      end
      send_pixel(x, y, $urandom, 1);
    end
  endtask

  initial begin : stimulus
    bit [15:0] light_pick [6] = '{16'h8000, 16'h7fff, 16'hc000, 16'h4000, 16'h0000, 16'hdccd};
    bit [15:0] size_pick [10] = '{0, 3, 4, 5, 256, 257, 511, 8, 64, 255};
    board.load_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Default setting: center, rim, corners, beyond the edge, noise extremes.
    idling = 0;
    send_pixel(27, 27, 0, 0);
    send_pixel(28, 28, 255, 0);
    send_pixel(0, 0, 128, 0);
    send_pixel(255, 255, 255, 0);
    send_pixel(0, 27, 77, 0);
    send_pixel(55, 28, 200, 0);
    send_pixel(3, 27, 0, 0);
    send_pixel(52, 27, 255, 0);
    send_pixel(27, 3, 1, 0);
    send_pixel(27, 52, 254, 0);
    send_pixel(9, 9, 100, 0);
    send_pixel(46, 46, 100, 0);
    send_pixel(60, 20, 50, 0);
    send_pixel(170, 85, 170, 0);
    idling = 1;
    random_pixels(120);
    wait_drained();

    for (int phase = 0; phase < 10; phase++) begin
      idling = (phase % 3) != 2;
      write_reg(REG_BASE_RED, phase == 0 ? 16'hff00 : phase == 1 ? 16'h00ff : 16'($urandom));
      write_reg(REG_BASE_GREEN, phase == 0 ? 16'h00ff : phase == 1 ? 16'h0000 : 16'($urandom));
      write_reg(REG_BASE_BLUE, phase < 2 ? 16'h00ff : 16'($urandom));
      write_reg(REG_LIGHT_X, phase < 6 ? light_pick[phase] : 16'($urandom_range(0, 32768) - 16384));
      write_reg(REG_LIGHT_Y, phase < 6 ? light_pick[5 - phase] : 16'($urandom));
      write_reg(REG_LIGHT_Z, phase < 6 ? light_pick[(phase + 2) % 6]
                                       : 16'($urandom_range(0, 16384)));
      write_reg(REG_SPRITE_SIZE, size_pick[phase] | (16'($urandom) & 16'hfe00));
      if (phase == 4) write_reg(cfg_reg_e'(7), 16'($urandom));
      cfg_valid_i <= 0;
      random_pixels(phase == 4 ? 40 : 140);
      if (phase == 4) begin
        // Stop the sink for a long stretch so the pipeline fills and stalls.
        hold_cycles = 300;
        for (int k = 0; k < 120; k++) send_pixel($urandom, $urandom, $urandom, 0);
      end
      wait_drained();
    end

    $display("Shaded %0d pixels (%0d covered, %0d on the rim) over 11 register settings.",
             board.shaded_count, board.covered_count, board.rim_count);
    $display("Mismatches: %0d", board.mismatches);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
